>>> hdl/fmtt_pkg.sv
// ----------------------------------------------------------------------------
// Fractional millisecond tick timer package
// Shared widths, register indexes, reset values and the structs that
// travel between the timer's pipeline stages.
// ----------------------------------------------------------------------------
package fmtt_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd3;

  // Field widths
  localparam int CPM_W       = 24;
  localparam int FRAC_W      = 10;
  localparam int SCALE_W     = 32;
  localparam int TOTAL_W     = 64;
  localparam int ELAPSED_W   = 32;
  localparam int SCALE_SHIFT = 22;
  localparam int INTERP_W    = ELAPSED_W - SCALE_SHIFT;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 136;

  // Arithmetic constants
  localparam logic [TOTAL_W-1:0] MS_US      = 64'd1000;
  localparam logic [FRAC_W:0]    FRAC_LIMIT = 11'd1000;
  localparam logic [FRAC_W-1:0]  FRAC_MAX   = 10'd999;

  // Register reset values
  localparam logic [CPM_W-1:0]   CPM_RESET   = 24'd1000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd4194304;

  typedef struct packed {
    logic               enable;
    logic [CPM_W-1:0]   cycles_per_ms;
    logic [FRAC_W-1:0]  ms_fraction;
    logic [SCALE_W-1:0] us_scale;
  } cfg_t;

  // Result of one step as left in the state stage.
  typedef struct packed {
    logic [TOTAL_W-1:0]   ms_total;
    logic [TOTAL_W-1:0]   us_total;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 ms_event;
  } snap_t;

endpackage

>>> hdl/fmtt_state.sv
// ----------------------------------------------------------------------------
// Timer state stage
// Runs the down counter, the millisecond and microsecond totals and the
// fraction accumulator; its registers double as the first pipeline stage.
// ----------------------------------------------------------------------------
module fmtt_state import fmtt_pkg::*; #(
  parameter int COUNTER_BITS = 24
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  logic  in_tick,
  output logic  in_ready,
  input  logic  s1_take,
  output logic  s1_valid,
  output snap_t snap
);

  localparam int RW = 33;
  localparam logic [RW-1:0] CMAX = (RW'(1) << COUNTER_BITS) - RW'(1);

  logic [COUNTER_BITS-1:0] down_r, down_nxt, dec;
  logic [TOTAL_W-1:0]      ms_r, ms_nxt, us_r, us_nxt;
  logic [FRAC_W-1:0]       frac_r, frac_nxt, frac_in;
  logic                    extra_r, extra_nxt;
  logic                    event_r, event_nxt;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic                    v1_r, v1_nxt;
  logic [CPM_W-1:0]        cpm_eff;
  logic [RW-1:0]           reload_raw, reload_sat;
  logic [FRAC_W:0]         frac_sum;
  logic                    accept;

  assign in_ready = !v1_r || s1_take;
  assign accept   = in_valid && in_ready;

  assign cpm_eff    = (cfg.cycles_per_ms == '0) ? CPM_W'(1) : cfg.cycles_per_ms;
  assign reload_raw = RW'(cpm_eff) - RW'(1) + RW'(extra_r);
  assign reload_sat = (reload_raw > CMAX) ? CMAX : reload_raw;
  assign dec        = down_r - COUNTER_BITS'(1);

  assign frac_in  = (cfg.ms_fraction > FRAC_MAX) ? FRAC_MAX : cfg.ms_fraction;
  assign frac_sum = {1'b0, frac_r} + {1'b0, frac_in};

  always_comb begin
    down_nxt  = down_r;
    ms_nxt    = ms_r;
    us_nxt    = us_r;
    frac_nxt  = frac_r;
    extra_nxt = extra_r;
    event_nxt = 1'b0;
    if (in_tick && cfg.enable) begin
      if (down_r == '0) begin
        down_nxt = reload_sat[COUNTER_BITS-1:0];
      end else begin
        down_nxt = dec;
        if (dec == '0) begin
          event_nxt = 1'b1;
          ms_nxt    = ms_r + TOTAL_W'(1);
          us_nxt    = us_r + MS_US;
          if (frac_sum >= FRAC_LIMIT) begin
            frac_nxt  = FRAC_W'(frac_sum - FRAC_LIMIT);
            extra_nxt = 1'b1;
          end else begin
            frac_nxt  = frac_sum[FRAC_W-1:0];
            extra_nxt = 1'b0;
          end
        end
      end
    end
    elapsed_nxt = ELAPSED_W'(cfg.cycles_per_ms) - ELAPSED_W'(1) - ELAPSED_W'(down_nxt);
  end

  always_comb begin
    v1_nxt = v1_r;
    if (accept) begin
      v1_nxt = 1'b1;
    end else if (s1_take) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r  <= '0;
      ms_r    <= '0;
      us_r    <= '0;
      frac_r  <= '0;
      extra_r <= 1'b0;
      event_r <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      if (accept) begin
        down_r  <= down_nxt;
        ms_r    <= ms_nxt;
        us_r    <= us_nxt;
        frac_r  <= frac_nxt;
        extra_r <= extra_nxt;
        event_r <= event_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  assign s1_valid      = v1_r;
  assign snap.ms_total = ms_r;
  assign snap.us_total = us_r;
  assign snap.elapsed  = elapsed_r;
  assign snap.ms_event = event_r;

endmodule

>>> hdl/fmtt_interp.sv
// ----------------------------------------------------------------------------
// Microsecond interpolation stages
// Scales the elapsed counter clocks into microseconds, then adds the
// microsecond total into the output register.
// ----------------------------------------------------------------------------
module fmtt_interp import fmtt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] us_scale,
  input  logic               s1_valid,
  input  snap_t              snap,
  output logic               s1_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOTAL_W-1:0] out_millis,
  output logic [TOTAL_W-1:0] out_micros,
  output logic               out_event
);

  logic [ELAPSED_W-1:0] prod;
  logic                 v2_r, v3_r;
  logic                 adv3, adv2;
  logic [TOTAL_W-1:0]   ms2_r, us2_r, millis_r, micros_r;
  logic [INTERP_W-1:0]  interp2_r;
  logic                 event2_r, event_r;

  // Product is kept to 32 bits before the shift.
  assign prod = snap.elapsed * us_scale;

  assign adv3    = !v3_r || out_ready;
  assign adv2    = !v2_r || adv3;
  assign s1_take = s1_valid && adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv2) begin
        v2_r <= s1_valid;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      ms2_r     <= snap.ms_total;
      us2_r     <= snap.us_total;
      interp2_r <= prod[ELAPSED_W-1:SCALE_SHIFT];
      event2_r  <= snap.ms_event;
    end
    if (adv3 && v2_r) begin
      millis_r <= ms2_r;
      micros_r <= us2_r + TOTAL_W'(interp2_r);
      event_r  <= event2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_millis = millis_r;
  assign out_micros = micros_r;
  assign out_event  = event_r;

endmodule

>>> hdl/fractional_millisecond_tick_timer_core.sv
// ----------------------------------------------------------------------------
// Fractional millisecond tick timer core
// A result reaches the output register through the state stage, the
// multiply stage and the add stage. Throughput: one input transfer per
// cycle unless the result stream stalls; the state update is a single
// registered step, and the 32x32 scale multiply has a stage of its own.
// Reset (rst_n low, synchronous) clears the counter, totals, accumulator and
// pipeline and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module fractional_millisecond_tick_timer_core import fmtt_pkg::*; #(
  parameter int COUNTER_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] clock_tick, rest zero
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [63:0] millis_now,
                                             // [127:64] micros_now,
                                             // [128] ms_event, rest zero
);

  cfg_t  cfg_r;
  snap_t snap;
  logic  s1_valid, s1_take;
  logic  in_accept;
  logic [TOTAL_W-1:0] millis, micros;
  logic  ms_event;

  // Always ready; every stage reads the configuration registers directly, so
  // software must write them only while the timer is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.cycles_per_ms <= CPM_RESET;
      cfg_r.ms_fraction   <= '0;
      cfg_r.us_scale      <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:   cfg_r.enable        <= cfg_data[0];
        REG_CYCLES:   cfg_r.cycles_per_ms <= cfg_data[CPM_W-1:0];
        REG_FRACTION: cfg_r.ms_fraction   <= cfg_data[FRAC_W-1:0];
        REG_SCALE:    cfg_r.us_scale      <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // The state stage holds the live counter and totals. Because it only takes
  // a new item when its previous result moves on, those registers are also
  // the first pipeline stage's snapshot of the step just done.
  fmtt_state #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_tick  (in_tdata[0]),
    .in_ready (in_tready),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .snap     (snap)
  );

  // Interpolation: the elapsed counter clocks times the scale, upper ten
  // bits of the 32-bit product, added to the microsecond total.
  fmtt_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .us_scale   (cfg_r.us_scale),
    .s1_valid   (s1_valid),
    .snap       (snap),
    .s1_take    (s1_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_millis (millis),
    .out_micros (micros),
    .out_event  (ms_event)
  );

  assign out_tdata = {7'b0, ms_event, micros, millis};
  assign in_accept = in_tvalid && in_tready;

  // A transfer without a clock tick leaves the totals alone and ends no
  // millisecond.
  a_idle_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_tdata[0] |=> $stable(snap.ms_total) && !snap.ms_event)
    else $error("idle step changed the millisecond total");

  // An ended millisecond advances the millisecond total by exactly one.
  a_event_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept ##1 snap.ms_event |-> snap.ms_total == $past(snap.ms_total) + 64'd1)
    else $error("millisecond event without a single increment");

  // The input side only stalls while the state stage holds a result that
  // has not yet moved into the multiply stage.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid)
    else $error("input stalled with an empty state stage");

endmodule
